FILE: design/psts_pkg.sv
// Shared types and codes for the priority time-slice task scheduler.
`default_nettype none

package psts_pkg;

   // Operation codes
   localparam logic [2:0] KIND_CREATE  = 3'd0;
   localparam logic [2:0] KIND_PICK    = 3'd1;
   localparam logic [2:0] KIND_WAIT    = 3'd2;
   localparam logic [2:0] KIND_DEC     = 3'd3;
   localparam logic [2:0] KIND_REFILL  = 3'd4;
   localparam logic [2:0] KIND_REMOVE  = 3'd5;
   localparam logic [2:0] KIND_RUN     = 3'd6;
   // No operation behind it: the slot is echoed, nothing changes
   localparam logic [2:0] KIND_IGNORED = 3'd7;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_IDLE  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   // Task states
   localparam logic [1:0] JOB_READY    = 2'd0;
   localparam logic [1:0] JOB_WAITING  = 2'd1;
   localparam logic [1:0] JOB_RUNNING  = 2'd2;

   // Most negative slice count
   localparam logic signed [8:0] SLICE_MIN = -9'sd256;

   typedef struct packed {
      logic              used;
      logic [1:0]        tstate;
      logic [7:0]        prio;
      logic signed [8:0] slice;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ACCESS,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

FILE: design/psts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module psts_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/priority_slice_task_scheduler.sv
// Top level of the priority time-slice task scheduler.
//
// A table of SLOTS task slots held in one RAM (used flag, state, priority and
// signed slice counter per entry). One operation is taken when start is high
// and busy is low; its single result appears on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, and the receiver cannot stall it. Kind 7 and a
// slot number at or above SLOTS are answered straight from idle; set waiting,
// decrement, refill, remove and set running read the entry, then modify and
// write it back; create scans through the one-read-per-cycle RAM port up to the
// first free slot; pick next scans the whole table for a ready task and, when
// none exists, makes a second pass that refills the waiting tasks. busy falls
// in the cycle the result is shown. After reset a clearing pass zeroes the RAM,
// with busy high.
`default_nettype none

module priority_slice_task_scheduler #(
   parameter int SLOTS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_kind,
   input  wire logic [6:0]        req_slot,
   input  wire logic [7:0]        req_priority_req,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [6:0]             rsp_chosen_slot,
   output logic signed [8:0]      rsp_counter_out
);

   localparam int IW = $clog2(SLOTS);
   localparam int EW = $bits(psts_pkg::entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   psts_pkg::state_type state_ff, state_in;

   logic                  phase_ff, phase_in;       // pick: 0 ready pass, 1 refill pass
   logic [IW-1:0]         idx_ff, idx_in;           // entry whose read data is due
   logic [2:0]            kind_ff, kind_in;
   logic [6:0]            slot_ff, slot_in;
   logic [7:0]            prio_ff, prio_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   logic [7:0]            best_prio_ff, best_prio_in;
   logic signed [8:0]     best_slice_ff, best_slice_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [6:0]            rsp_chosen_ff, rsp_chosen_in;
   logic signed [8:0]     rsp_counter_ff, rsp_counter_in;

   // RAM port signals
   logic                  ram_we;
   logic [IW-1:0]         ram_waddr;
   logic [IW-1:0]         ram_raddr;
   psts_pkg::entry_type   ram_wdata;
   psts_pkg::entry_type   ram_rdata;
   logic [EW-1:0]         ram_rdata_raw;

   // Scan helpers
   logic                  accept;
   logic                  last;
   logic [1:0]            want;
   logic                  cand;
   psts_pkg::entry_type   upd;

   assign busy   = (state_ff != psts_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign last   = (idx_ff == LAST_IDX);
   assign ram_rdata = psts_pkg::entry_type'(ram_rdata_raw);

   psts_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (EW'(ram_wdata)),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   // The pass of pick next looks for ready tasks first, then waiting ones.
   assign want = phase_ff ? psts_pkg::JOB_WAITING : psts_pkg::JOB_READY;
   // Strict compare: the lowest slot keeps a tie.
   assign cand = ram_rdata.used && (ram_rdata.tstate == want) &&
                 (!found_ff || (ram_rdata.prio > best_prio_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psts_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      prio_ff        <= prio_in;
      best_idx_ff    <= best_idx_in;
      best_prio_ff   <= best_prio_in;
      best_slice_ff  <= best_slice_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_counter_ff <= rsp_counter_in;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      prio_in        = prio_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      best_slice_in  = best_slice_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_counter_in = rsp_counter_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = '0;
      ram_raddr      = idx_ff + IW'(1);
      upd            = ram_rdata;

      unique case (state_ff)
         psts_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            idx_in    = idx_ff + IW'(1);
            if (last) begin
               idx_in   = '0;
               state_in = psts_pkg::ST_IDLE;
            end
         end

         psts_pkg::ST_IDLE: begin
            ram_raddr = '0;
            if (accept) begin
               kind_in  = req_kind;
               slot_in  = req_slot;
               prio_in  = req_priority_req;
               phase_in = 1'b0;
               found_in = 1'b0;
               idx_in   = '0;
               if ((req_kind == psts_pkg::KIND_CREATE) ||
                   (req_kind == psts_pkg::KIND_PICK)) begin
                  state_in = psts_pkg::ST_SCAN;
               end else if (req_kind == psts_pkg::KIND_IGNORED) begin
                  // Unknown kind: echo the slot, change nothing
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = psts_pkg::STATUS_OK;
                  rsp_chosen_in  = req_slot;
                  rsp_counter_in = '0;
               end else if (32'(req_slot) >= 32'(SLOTS)) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = psts_pkg::STATUS_EMPTY;
                  rsp_chosen_in  = req_slot;
                  rsp_counter_in = '0;
               end else begin
                  ram_raddr = IW'(req_slot);
                  state_in  = psts_pkg::ST_ACCESS;
               end
            end
         end

         psts_pkg::ST_SCAN: begin
            idx_in = idx_ff + IW'(1);
            if (kind_ff == psts_pkg::KIND_CREATE) begin
               if (!ram_rdata.used) begin
                  ram_we          = 1'b1;
                  ram_wdata.used  = 1'b1;
                  ram_wdata.tstate = psts_pkg::JOB_READY;
                  ram_wdata.prio  = prio_ff;
                  ram_wdata.slice = $signed({1'b0, prio_ff});
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = psts_pkg::STATUS_OK;
                  rsp_chosen_in   = 7'(idx_ff);
                  rsp_counter_in  = '0;
                  idx_in          = '0;
                  state_in        = psts_pkg::ST_IDLE;
               end else if (last) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = psts_pkg::STATUS_FULL;
                  rsp_chosen_in  = '0;
                  rsp_counter_in = '0;
                  idx_in         = '0;
                  state_in       = psts_pkg::ST_IDLE;
               end
            end else begin
               if (phase_ff && ram_rdata.used &&
                   (ram_rdata.tstate == psts_pkg::JOB_WAITING)) begin
                  // Refill pass: fresh slice, back to ready
                  ram_we           = 1'b1;
                  ram_wdata        = ram_rdata;
                  ram_wdata.tstate = psts_pkg::JOB_READY;
                  ram_wdata.slice  = $signed({1'b0, ram_rdata.prio});
               end
               if (cand) begin
                  found_in      = 1'b1;
                  best_idx_in   = idx_ff;
                  best_prio_in  = ram_rdata.prio;
                  best_slice_in = phase_ff ? $signed({1'b0, ram_rdata.prio})
                                           : ram_rdata.slice;
               end
               if (last) begin
                  idx_in = '0;
                  if (found_ff || cand) begin
                     state_in = psts_pkg::ST_COMMIT;
                  end else if (!phase_ff) begin
                     phase_in  = 1'b1;
                     ram_raddr = '0;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = psts_pkg::STATUS_IDLE;
                     rsp_chosen_in  = '0;
                     rsp_counter_in = '0;
                     state_in       = psts_pkg::ST_IDLE;
                  end
               end
            end
         end

         psts_pkg::ST_ACCESS: begin
            rsp_valid_in   = 1'b1;
            rsp_chosen_in  = slot_ff;
            rsp_counter_in = '0;
            idx_in         = '0;
            state_in       = psts_pkg::ST_IDLE;
            ram_waddr      = IW'(slot_ff);
            if (!ram_rdata.used) begin
               rsp_status_in = psts_pkg::STATUS_EMPTY;
            end else begin
               rsp_status_in = psts_pkg::STATUS_OK;
               case (kind_ff)
                  psts_pkg::KIND_WAIT: begin
                     upd.tstate = psts_pkg::JOB_WAITING;
                  end
                  psts_pkg::KIND_DEC: begin
                     if (ram_rdata.slice != psts_pkg::SLICE_MIN) begin
                        upd.slice = ram_rdata.slice - 9'sd1;
                     end
                     rsp_counter_in = upd.slice;
                  end
                  psts_pkg::KIND_REFILL: begin
                     upd.slice      = $signed({1'b0, ram_rdata.prio});
                     rsp_counter_in = upd.slice;
                  end
                  psts_pkg::KIND_REMOVE: begin
                     upd.used = 1'b0;
                  end
                  default: begin
                     upd.tstate = psts_pkg::JOB_RUNNING;
                  end
               endcase
               ram_we    = 1'b1;
               ram_wdata = upd;
            end
         end

         psts_pkg::ST_COMMIT: begin
            ram_we           = 1'b1;
            ram_waddr        = best_idx_ff;
            ram_wdata.used   = 1'b1;
            ram_wdata.tstate = psts_pkg::JOB_RUNNING;
            ram_wdata.prio   = best_prio_ff;
            ram_wdata.slice  = best_slice_ff;
            rsp_valid_in     = 1'b1;
            rsp_status_in    = psts_pkg::STATUS_OK;
            rsp_chosen_in    = 7'(best_idx_ff);
            rsp_counter_in   = '0;
            idx_in           = '0;
            state_in         = psts_pkg::ST_IDLE;
         end

         default: begin
            state_in = psts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_slot = rsp_chosen_ff;
   assign rsp_counter_out = rsp_counter_ff;

   // The commit write only follows a pass that found a task.
   a_commit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psts_pkg::ST_COMMIT) |-> found_ff)
      else $error("commit without a chosen task");

   // The ready pass of pick next only reads the table.
   a_ready_pass_ro: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == psts_pkg::ST_SCAN) && (kind_ff == psts_pkg::KIND_PICK) &&
       !phase_ff) |-> !ram_we)
      else $error("write during ready pass");

   // A pick next transfer always starts a scan.
   a_pick_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == psts_pkg::KIND_PICK)) |=>
      (state_ff == psts_pkg::ST_SCAN))
      else $error("pick next did not scan");

endmodule

`default_nettype wire

FILE: test/psts_sched_checker.sv
// Checker for the task scheduler: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps

module psts_sched_checker #(
   parameter int SLOTS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [2:0]        req_kind,
   input  wire logic [6:0]        req_slot,
   input  wire logic [7:0]        req_priority_req,
   input  wire logic              rsp_valid,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [6:0]        rsp_chosen_slot,
   input  wire logic signed [8:0] rsp_counter_out,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [1:0]        status;
      logic [6:0]        chosen;
      logic signed [8:0] counter;
   } sched_result_type;

   // shadow task table
   bit         task_used  [SLOTS];
   logic [1:0] task_state [SLOTS];
   logic [7:0] task_prio  [SLOTS];
   int         task_slice [SLOTS];

   sched_result_type awaited_results[$];
   int               fails = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic apply_sched_op(input logic [2:0] kind, input logic [6:0] slot,
                                 input logic [7:0] prio_in,
                                 output sched_result_type res);
      int best;
      int s;
      best        = -1;
      s           = slot;
      res.status  = psts_pkg::STATUS_OK;
      res.chosen  = slot;
      res.counter = '0;
      case (kind)
         psts_pkg::KIND_CREATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (!task_used[i] && best < 0) best = i;
            if (best < 0) begin
               res.status = psts_pkg::STATUS_FULL;
               res.chosen = '0;
            end else begin
               task_used[best]  = 1'b1;
               task_prio[best]  = prio_in;
               task_slice[best] = prio_in;
               task_state[best] = psts_pkg::JOB_READY;
               res.chosen       = best[6:0];
            end
         end
         psts_pkg::KIND_PICK: begin
            for (int i = 0; i < SLOTS; i++)
               if (task_used[i] && task_state[i] == psts_pkg::JOB_READY &&
                   (best < 0 || task_prio[i] > task_prio[best])) best = i;
            // nothing ready: refill every waiting task and choose among them
            if (best < 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (task_used[i] && task_state[i] == psts_pkg::JOB_WAITING) begin
                     task_slice[i] = task_prio[i];
                     task_state[i] = psts_pkg::JOB_READY;
                     if (best < 0 || task_prio[i] > task_prio[best]) best = i;
                  end
               end
            end
            if (best < 0) begin
               res.status = psts_pkg::STATUS_IDLE;
               res.chosen = '0;
            end else begin
               task_state[best] = psts_pkg::JOB_RUNNING;
               res.chosen       = best[6:0];
            end
         end
         psts_pkg::KIND_WAIT, psts_pkg::KIND_DEC, psts_pkg::KIND_REFILL,
         psts_pkg::KIND_REMOVE, psts_pkg::KIND_RUN: begin
            if (s >= SLOTS || !task_used[s]) begin
               res.status = psts_pkg::STATUS_EMPTY;
            end else begin
               case (kind)
                  psts_pkg::KIND_WAIT: task_state[s] = psts_pkg::JOB_WAITING;
                  psts_pkg::KIND_DEC: begin
                     if (task_slice[s] > psts_pkg::SLICE_MIN)
                        task_slice[s] = task_slice[s] - 1;
                     res.counter = task_slice[s][8:0];
                  end
                  psts_pkg::KIND_REFILL: begin
                     task_slice[s] = task_prio[s];
                     res.counter   = task_slice[s][8:0];
                  end
                  psts_pkg::KIND_REMOVE: task_used[s] = 1'b0;
                  default: task_state[s] = psts_pkg::JOB_RUNNING;
               endcase
            end
         end
         default: ;  // unassigned kind: echoes the slot, no change
      endcase
   endtask

   always @(posedge clock) begin : monitor
      sched_result_type want;
      sched_result_type got;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) task_used[i] = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_chosen_slot, rsp_counter_out};
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited: status %0d slot %0d counter %0d",
                      got.status, got.chosen, got.counter);
               fails++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fails++;
               end
               if (got.chosen !== want.chosen) begin
                  $error("chosen_slot: expected %0d, got %0d", want.chosen, got.chosen);
                  fails++;
               end
               if (got.counter !== want.counter) begin
                  $error("counter_out: expected %0d, got %0d", want.counter, got.counter);
                  fails++;
               end
            end
         end
         if (start && !busy) begin
            apply_sched_op(req_kind, req_slot, req_priority_req, want);
            awaited_results.push_back(want);
         end
      end
      fail_count <= fails;
      pending    <= awaited_results.size();
   end

endmodule

FILE: test/priority_slice_task_scheduler_tb.sv
// Testbench top for the task scheduler: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module priority_slice_task_scheduler_tb;

   localparam int SLOTS          = 128;
   localparam int PHASE_ITEMS    = 480;
   // longest pick is two full scans; allow generous slack for sender gaps
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * SLOTS + 16;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic [2:0]        req_kind         = '0;
   logic [6:0]        req_slot         = '0;
   logic [7:0]        req_priority_req = '0;
   logic              busy;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [6:0]        rsp_chosen_slot;
   logic signed [8:0] rsp_counter_out;

   int fail_count;
   int pending;

   int send_idle_pct = 0;
   int ops_sent      = 0;
   int kind_count [8];

   always #5 clock = ~clock;

   priority_slice_task_scheduler #(.SLOTS(SLOTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_slot         (req_slot),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_chosen_slot  (rsp_chosen_slot),
      .rsp_counter_out  (rsp_counter_out)
   );

   psts_sched_checker #(.SLOTS(SLOTS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_slot         (req_slot),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_chosen_slot  (rsp_chosen_slot),
      .rsp_counter_out  (rsp_counter_out),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // One command transfer. Random gaps with start low come first; then the
   // command is held until an edge sees busy low. start is left high on
   // return so that a back-to-back command never drops it within a step.
   task automatic issue_op(input logic [2:0] kind, input logic [6:0] slot,
                           input logic [7:0] prio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_slot         <= slot;
      req_priority_req <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      kind_count[kind] += 1;
      ops_sent         += 1;
   endtask

   // Creates fill the lowest free slots, so most addressed operations go to
   // the low end of the table where tasks actually live.
   function automatic logic [6:0] near_slot();
      if ($urandom_range(0, 99) < 75) return 7'($urandom_range(0, 15));
      return 7'($urandom_range(0, SLOTS - 1));
   endfunction

   task automatic random_single_op();
      int          r;
      logic [2:0]  kind;
      r = $urandom_range(0, 99);
      if      (r < 16) kind = psts_pkg::KIND_CREATE;
      else if (r < 34) kind = psts_pkg::KIND_PICK;
      else if (r < 46) kind = psts_pkg::KIND_WAIT;
      else if (r < 62) kind = psts_pkg::KIND_DEC;
      else if (r < 72) kind = psts_pkg::KIND_REFILL;
      else if (r < 86) kind = psts_pkg::KIND_REMOVE;
      else if (r < 98) kind = psts_pkg::KIND_RUN;
      else             kind = psts_pkg::KIND_IGNORED;
      issue_op(kind, near_slot(), 8'($urandom));
   endtask

   // Mostly well-formed sequences with random content: a group of tasks put
   // to waiting and then picked (may force the refill pass), a run of
   // decrements on one task, otherwise lone random commands.
   task automatic random_sequence();
      int r;
      int n;
      logic [6:0] s;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         n = $urandom_range(2, 12);
         for (int i = 0; i < n; i++) issue_op(psts_pkg::KIND_WAIT, 7'(i), 8'($urandom));
         issue_op(psts_pkg::KIND_PICK, 7'($urandom), 8'($urandom));
         issue_op(psts_pkg::KIND_PICK, 7'($urandom), 8'($urandom));
      end else if (r < 18) begin
         s = near_slot();
         repeat ($urandom_range(2, 12)) issue_op(psts_pkg::KIND_DEC, s, 8'($urandom));
      end else begin
         random_single_op();
      end
   endtask

   // Drive the table past full, then free a scattered set of slots.
   task automatic fill_table();
      repeat (SLOTS + 2) issue_op(psts_pkg::KIND_CREATE, 7'($urandom), 8'($urandom));
      repeat (60) issue_op(psts_pkg::KIND_REMOVE, 7'($urandom_range(0, SLOTS - 1)),
                           8'($urandom));
   endtask

   // Slot 0 is freed, so the next create lands there with a zero slice;
   // enough decrements then pin the counter at its floor.
   task automatic saturate_counter();
      issue_op(psts_pkg::KIND_REMOVE, 7'd0, 8'($urandom));
      issue_op(psts_pkg::KIND_CREATE, 7'($urandom), 8'd0);
      repeat (262) issue_op(psts_pkg::KIND_DEC, 7'd0, 8'($urandom));
      issue_op(psts_pkg::KIND_REFILL, 7'd0, 8'($urandom));
   endtask

   task automatic directed_ops();
      issue_op(psts_pkg::KIND_PICK,    7'd0,   8'd0);    // empty table: nothing to run
      issue_op(psts_pkg::KIND_WAIT,    7'd0,   8'd255);  // addressed slots all empty
      issue_op(psts_pkg::KIND_DEC,     7'd127, 8'd0);
      issue_op(psts_pkg::KIND_REFILL,  7'd64,  8'd255);
      issue_op(psts_pkg::KIND_REMOVE,  7'd1,   8'd0);
      issue_op(psts_pkg::KIND_RUN,     7'd127, 8'd255);
      issue_op(psts_pkg::KIND_IGNORED, 7'd127, 8'd255);
      issue_op(psts_pkg::KIND_CREATE,  7'd127, 8'd0);    // slot 0, lowest priority
      issue_op(psts_pkg::KIND_CREATE,  7'd0,   8'd255);  // slot 1
      issue_op(psts_pkg::KIND_CREATE,  7'd0,   8'd255);  // slot 2, ties slot 1
      issue_op(psts_pkg::KIND_DEC,     7'd0,   8'd0);    // zero slice goes negative
      issue_op(psts_pkg::KIND_REFILL,  7'd0,   8'd0);
      issue_op(psts_pkg::KIND_PICK,    7'd127, 8'd0);    // tie: lower slot wins
      issue_op(psts_pkg::KIND_PICK,    7'd0,   8'd0);
      issue_op(psts_pkg::KIND_PICK,    7'd0,   8'd0);    // lowest-priority task
      issue_op(psts_pkg::KIND_PICK,    7'd0,   8'd0);    // all running: nothing to run
      issue_op(psts_pkg::KIND_WAIT,    7'd1,   8'd0);
      issue_op(psts_pkg::KIND_WAIT,    7'd2,   8'd0);
      issue_op(psts_pkg::KIND_PICK,    7'd0,   8'd0);    // waiting tasks refilled
      issue_op(psts_pkg::KIND_DEC,     7'd1,   8'd0);
      issue_op(psts_pkg::KIND_RUN,     7'd0,   8'd0);
      issue_op(psts_pkg::KIND_REMOVE,  7'd2,   8'd0);
      issue_op(psts_pkg::KIND_CREATE,  7'd0,   8'd128);  // reuses freed slot 2
      issue_op(psts_pkg::KIND_IGNORED, 7'd0,   8'd0);
   endtask

   // Watchdog: any stretch with neither a command nor a result transfer
   // beyond the limit means the block has hung.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int idle_pct [3];
      int phase_base;
      int special_at;
      bit special_done;
      idle_pct = '{35, 57, 0};
      for (int k = 0; k < 8; k++) kind_count[k] = 0;

      // single reset; the block then clears its table with busy high,
      // which the first transfer simply waits out
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_ops();

      // three idling phases, each with one long structured sequence
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = idle_pct[phase];
         phase_base    = ops_sent;
         special_at    = $urandom_range(40, 250);
         special_done  = 1'b0;
         while (ops_sent - phase_base < PHASE_ITEMS) begin
            if (!special_done && ops_sent - phase_base >= special_at) begin
               special_done = 1'b1;
               if (phase == 1) saturate_counter();
               else            fill_table();
            end else begin
               random_sequence();
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending != 0) $error("%0d results never arrived", pending);
      $display("%0d commands: %0d create, %0d pick, %0d wait, %0d dec,",
               ops_sent, kind_count[psts_pkg::KIND_CREATE],
               kind_count[psts_pkg::KIND_PICK], kind_count[psts_pkg::KIND_WAIT],
               kind_count[psts_pkg::KIND_DEC]);
      $display("   %0d refill, %0d remove, %0d run, %0d other",
               kind_count[psts_pkg::KIND_REFILL], kind_count[psts_pkg::KIND_REMOVE],
               kind_count[psts_pkg::KIND_RUN], kind_count[psts_pkg::KIND_IGNORED]);
      $display("sender gaps at 35%%, 57%% and none; table overfilled twice, slice floor reached once");
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/psts_pkg.sv
design/psts_ram.sv
design/priority_slice_task_scheduler.sv
test/psts_sched_checker.sv
test/priority_slice_task_scheduler_tb.sv
